@@ rtl/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// Circular deque package
// Shared constants, codes and types for the deque cell row.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef enum logic [1:0] {
    ACT_PUSH_REAR  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_PUSH_FULL  = 2'd1,
    ST_POP_EMPTY  = 2'd2
  } status_t;

  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic load_push;
    logic is_last;
  } cell_ctl_t;

endpackage

@@ rtl/cdq_if.sv @@
// ----------------------------------------------------------------------------
// Circular deque channels
// Valid/ready channels for requests into the deque and results out of it.
// ----------------------------------------------------------------------------
interface cdq_in_if;
  logic              valid;
  logic              ready;
  cdq_pkg::action_t  action;
  cdq_pkg::word_t    push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface cdq_out_if;
  logic              valid;
  logic              ready;
  cdq_pkg::status_t  status;
  cdq_pkg::word_t    popped_value;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, output status, output popped_value, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input status, input popped_value, input is_empty,
                  input is_full, output ready);
endinterface

@@ rtl/cdq_cell.sv @@
// ----------------------------------------------------------------------------
// Deque cell
// Holds one entry and takes its next value from a neighbor or the push word.
// ----------------------------------------------------------------------------
module cdq_cell (
  input  logic               clk,
  input  cdq_pkg::cell_ctl_t ctl,
  input  cdq_pkg::word_t     left_data,
  input  cdq_pkg::word_t     right_data,
  input  cdq_pkg::word_t     push_value,
  output cdq_pkg::word_t     data,
  output cdq_pkg::word_t     rear_tap
);

  always_ff @(posedge clk) begin
    if (ctl.shift_right) begin
      data <= left_data;
    end else if (ctl.shift_left) begin
      data <= right_data;
    end else if (ctl.load_push) begin
      data <= push_value;
    end
  end

  assign rear_tap = ctl.is_last ? data : '0;

endmodule

@@ rtl/circular_deque.sv @@
// ----------------------------------------------------------------------------
// Circular deque
// Double-ended queue built as a row of cells with the front entry in cell 0.
// ----------------------------------------------------------------------------
//   Channel   Dir   Payload
//   in_ch     in    action, push_value
//   out_ch    out   status, popped_value, is_empty, is_full
//
// One request is taken per cycle while the input is ready; its result appears
// in the output register on the next cycle. Every cell updates in the same
// cycle as the output register. Reset clears the entry count and the output
// register's valid flag and holds the input not ready; no clearing pass is
// needed. The input stalls only while a result waits in the output register
// and the sink is not ready.
// ----------------------------------------------------------------------------
module circular_deque (
  input  logic      clk,
  input  logic      rst,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);

  cdq_pkg::count_t    count;
  cdq_pkg::count_t    count_next;
  cdq_pkg::word_t     cell_data [cdq_pkg::DEPTH];
  cdq_pkg::word_t     rear_tap  [cdq_pkg::DEPTH];
  cdq_pkg::cell_ctl_t cell_ctl  [cdq_pkg::DEPTH];
  cdq_pkg::word_t     rear_value;
  cdq_pkg::status_t   status_next;
  cdq_pkg::word_t     popped_next;

  logic accept;
  logic full;
  logic empty;
  logic is_push;
  logic op_ok;
  logic do_push_rear;
  logic do_push_front;
  logic do_pop_front;
  logic do_pop_rear;

  assign in_ch.ready = !rst && (!out_ch.valid || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count == cdq_pkg::count_t'(cdq_pkg::DEPTH));
  assign empty       = (count == '0);
  assign is_push     = (in_ch.action == cdq_pkg::ACT_PUSH_REAR) ||
                       (in_ch.action == cdq_pkg::ACT_PUSH_FRONT);
  assign op_ok       = is_push ? !full : !empty;

  assign do_push_rear  = accept && op_ok && (in_ch.action == cdq_pkg::ACT_PUSH_REAR);
  assign do_push_front = accept && op_ok && (in_ch.action == cdq_pkg::ACT_PUSH_FRONT);
  assign do_pop_front  = accept && op_ok && (in_ch.action == cdq_pkg::ACT_POP_FRONT);
  assign do_pop_rear   = accept && op_ok && (in_ch.action == cdq_pkg::ACT_POP_REAR);

  for (genvar i = 0; i < cdq_pkg::DEPTH; i++) begin : g_cell
    cdq_pkg::word_t left_data;
    cdq_pkg::word_t right_data;

    if (i == 0) begin : g_first
      assign left_data = in_ch.push_value;
    end else begin : g_inner
      assign left_data = cell_data[i-1];
    end

    if (i == cdq_pkg::DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_body
      assign right_data = cell_data[i+1];
    end

    assign cell_ctl[i].shift_right = do_push_front;
    assign cell_ctl[i].shift_left  = do_pop_front;
    assign cell_ctl[i].load_push   = do_push_rear && (count == cdq_pkg::count_t'(i));
    assign cell_ctl[i].is_last     = (count == cdq_pkg::count_t'(i + 1));

    cdq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .left_data  (left_data),
      .right_data (right_data),
      .push_value (in_ch.push_value),
      .data       (cell_data[i]),
      .rear_tap   (rear_tap[i])
    );
  end

  always_comb begin
    rear_value = '0;
    for (int i = 0; i < cdq_pkg::DEPTH; i++) begin
      rear_value = rear_value | rear_tap[i];
    end
  end

  always_comb begin
    count_next  = count;
    status_next = cdq_pkg::ST_DONE;
    popped_next = '0;
    if (accept) begin
      priority if (!op_ok && is_push) begin
        status_next = cdq_pkg::ST_PUSH_FULL;
      end else if (!op_ok) begin
        status_next = cdq_pkg::ST_POP_EMPTY;
      end else if (is_push) begin
        count_next = count + cdq_pkg::count_t'(1);
      end else begin
        count_next  = count - cdq_pkg::count_t'(1);
        popped_next = do_pop_front ? cell_data[0] : rear_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.status       <= status_next;
      out_ch.popped_value <= popped_next;
      out_ch.is_empty     <= (count_next == '0);
      out_ch.is_full      <= (count_next == cdq_pkg::count_t'(cdq_pkg::DEPTH));
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cdq_pkg::count_t'(cdq_pkg::DEPTH))
    else $error("entry count exceeds depth");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !op_ok |=> count == $past(count))
    else $error("rejected transaction changed the entry count");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push_rear || do_push_front) |=> count == $past(count) + cdq_pkg::count_t'(1))
    else $error("push did not add one entry");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid)
    else $error("accepted transaction produced no result");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.is_empty == (count == '0))
    else $error("empty flag disagrees with entry count");

endmodule

@@ sim/circular_deque_tb.sv @@
// ----------------------------------------------------------------------------
// Circular deque testbench
// Sends push and pop requests through the request channel with random gaps,
// while the result channel stalls at random. A behavioral deque model, or the
// table for pinned rows, predicts each transaction, and each result is
// checked field by field in order. A short directed table covers empty and
// full rejection, index wrap and value extremes. Random bursts, most favoring
// pushes or pops, then move the deque between empty and full many times.
// ----------------------------------------------------------------------------
module circular_deque_tb;

  localparam int RANDOM_ITEMS = 724;
  localparam int IDLE_PCT     = 23;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    cdq_pkg::status_t status;
    cdq_pkg::word_t   popped_value;
    logic             is_empty;
    logic             is_full;
  } deque_result_t;

  typedef struct packed {
    cdq_pkg::action_t act;
    cdq_pkg::word_t   value;
    int               reps;
    logic             pinned;
    deque_result_t    want;
  } stim_row_t;

  typedef struct packed {
    cdq_pkg::action_t act;
    cdq_pkg::word_t   value;
    logic             pinned;
    deque_result_t    want;
  } deque_req_t;

  logic clk;
  logic rst;

  cdq_in_if  req_ch ();
  cdq_out_if rsp_ch ();

  circular_deque i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  cdq_pkg::word_t deque_mem [cdq_pkg::DEPTH];
  int             head_idx;
  int             tail_idx;
  int             fill_count;

  deque_req_t     req_plan [$];
  deque_result_t  expected_results [$];
  stim_row_t      directed_rows [13];
  cdq_pkg::word_t corner_values [4];

  int             accepted_count;
  int             checked_count;
  int             mismatch_count;
  int             cycle_count;
  logic           calm;

  assign calm = (accepted_count >= 300) && (accepted_count < 450);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic deque_result_t deque_apply(cdq_pkg::action_t act,
                                                cdq_pkg::word_t value);
    deque_result_t res;
    res.status       = cdq_pkg::ST_DONE;
    res.popped_value = '0;
    if (act == cdq_pkg::ACT_PUSH_REAR || act == cdq_pkg::ACT_PUSH_FRONT) begin
      if (fill_count >= cdq_pkg::DEPTH) begin
        res.status = cdq_pkg::ST_PUSH_FULL;
      end else if (act == cdq_pkg::ACT_PUSH_REAR) begin
        deque_mem[tail_idx] = value;
        tail_idx = (tail_idx == cdq_pkg::DEPTH - 1) ? 0 : tail_idx + 1;
        fill_count++;
      end else begin
        head_idx = (head_idx == 0) ? cdq_pkg::DEPTH - 1 : head_idx - 1;
        deque_mem[head_idx] = value;
        fill_count++;
      end
    end else begin
      if (fill_count == 0) begin
        res.status = cdq_pkg::ST_POP_EMPTY;
      end else if (act == cdq_pkg::ACT_POP_FRONT) begin
        res.popped_value = deque_mem[head_idx];
        head_idx = (head_idx == cdq_pkg::DEPTH - 1) ? 0 : head_idx + 1;
        fill_count--;
      end else begin
        tail_idx = (tail_idx == 0) ? cdq_pkg::DEPTH - 1 : tail_idx - 1;
        res.popped_value = deque_mem[tail_idx];
        fill_count--;
      end
      if (fill_count == 0) begin
        head_idx = 0;
        tail_idx = 0;
      end
    end
    res.is_empty = (fill_count == 0);
    res.is_full  = (fill_count >= cdq_pkg::DEPTH);
    return res;
  endfunction

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("ERROR: %s", msg);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Results are checked before the transaction accepted at the same edge is
  // predicted, so the queue order always matches the output order.
  always @(posedge clk) begin : check_results
    deque_result_t want;
    deque_result_t model_res;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("unexpected result: status %0d, value %0d",
                               rsp_ch.status, rsp_ch.popped_value));
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          report_error($sformatf("result %0d status: expected %0d, got %0d",
                                 checked_count, want.status, rsp_ch.status));
        end
        if (rsp_ch.popped_value !== want.popped_value) begin
          report_error($sformatf("result %0d popped_value: expected %0d, got %0d",
                                 checked_count, want.popped_value,
                                 rsp_ch.popped_value));
        end
        if (rsp_ch.is_empty !== want.is_empty) begin
          report_error($sformatf("result %0d is_empty: expected %0b, got %0b",
                                 checked_count, want.is_empty, rsp_ch.is_empty));
        end
        if (rsp_ch.is_full !== want.is_full) begin
          report_error($sformatf("result %0d is_full: expected %0b, got %0b",
                                 checked_count, want.is_full, rsp_ch.is_full));
        end
        checked_count++;
      end
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      model_res = deque_apply(req_ch.action, req_ch.push_value);
      if (req_plan[accepted_count].pinned) begin
        expected_results.push_back(req_plan[accepted_count].want);
      end else begin
        expected_results.push_back(model_res);
      end
      accepted_count++;
    end
  end

  initial begin : drive_requests
    deque_req_t item;
    int         k;
    int         r;
    int         mode;
    int         burst;
    int         push_pct;

    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.action      = cdq_pkg::ACT_PUSH_REAR;
    req_ch.push_value  = '0;
    rsp_ch.ready       = 1'b0;
    head_idx           = 0;
    tail_idx           = 0;
    fill_count         = 0;
    accepted_count     = 0;
    checked_count      = 0;
    mismatch_count     = 0;
    cycle_count        = 0;

    corner_values = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1};

    directed_rows = '{
      '{cdq_pkg::ACT_POP_FRONT,  32'sd0,          1,  1'b1,
        '{cdq_pkg::ST_POP_EMPTY, 32'sd0,          1'b1, 1'b0}},
      '{cdq_pkg::ACT_POP_REAR,   32'sd0,          1,  1'b1,
        '{cdq_pkg::ST_POP_EMPTY, 32'sd0,          1'b1, 1'b0}},
      '{cdq_pkg::ACT_PUSH_REAR,  32'sh7fff_ffff,  1,  1'b1,
        '{cdq_pkg::ST_DONE,      32'sd0,          1'b0, 1'b0}},
      '{cdq_pkg::ACT_PUSH_FRONT, 32'sh8000_0000,  1,  1'b1,
        '{cdq_pkg::ST_DONE,      32'sd0,          1'b0, 1'b0}},
      '{cdq_pkg::ACT_POP_FRONT,  32'sd0,          1,  1'b1,
        '{cdq_pkg::ST_DONE,      32'sh8000_0000,  1'b0, 1'b0}},
      '{cdq_pkg::ACT_POP_REAR,   32'sd0,          1,  1'b1,
        '{cdq_pkg::ST_DONE,      32'sh7fff_ffff,  1'b1, 1'b0}},
      '{cdq_pkg::ACT_PUSH_FRONT, -32'sd1,         1,  1'b1,
        '{cdq_pkg::ST_DONE,      32'sd0,          1'b0, 1'b0}},
      '{cdq_pkg::ACT_PUSH_REAR,  32'sh5555_5555,  14, 1'b0,
        '{cdq_pkg::ST_DONE,      32'sd0,          1'b0, 1'b0}},
      '{cdq_pkg::ACT_PUSH_REAR,  32'sd0,          1,  1'b1,
        '{cdq_pkg::ST_DONE,      32'sd0,          1'b0, 1'b1}},
      '{cdq_pkg::ACT_PUSH_FRONT, 32'shAAAA_AAAA,  1,  1'b1,
        '{cdq_pkg::ST_PUSH_FULL, 32'sd0,          1'b0, 1'b1}},
      '{cdq_pkg::ACT_PUSH_REAR,  32'sd1,          1,  1'b1,
        '{cdq_pkg::ST_PUSH_FULL, 32'sd0,          1'b0, 1'b1}},
      '{cdq_pkg::ACT_POP_REAR,   32'sd0,          1,  1'b1,
        '{cdq_pkg::ST_DONE,      32'sd0,          1'b0, 1'b0}},
      '{cdq_pkg::ACT_POP_FRONT,  32'sd0,          1,  1'b1,
        '{cdq_pkg::ST_DONE,      -32'sd1,         1'b0, 1'b0}}
    };

    foreach (directed_rows[i]) begin
      for (r = 0; r < directed_rows[i].reps; r++) begin
        item.act    = directed_rows[i].act;
        item.value  = directed_rows[i].value + r;
        item.pinned = directed_rows[i].pinned;
        item.want   = directed_rows[i].want;
        req_plan.push_back(item);
      end
    end

    // Bursts lean toward pushes or pops, or mix them evenly, so the deque swings
    // between empty and full again and again.
    k = req_plan.size() + RANDOM_ITEMS;
    while (req_plan.size() < k) begin
      mode     = $urandom_range(2);
      burst    = $urandom_range(40, 8);
      push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      repeat (burst) begin
        if ($urandom_range(99) < push_pct) begin
          item.act = cdq_pkg::action_t'($urandom_range(1));
        end else begin
          item.act = cdq_pkg::action_t'(2 + $urandom_range(1));
        end
        if ($urandom_range(15) == 0) begin
          item.value = corner_values[$urandom_range(3)];
        end else begin
          item.value = cdq_pkg::word_t'($urandom);
        end
        item.pinned = 1'b0;
        item.want   = '0;
        req_plan.push_back(item);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < req_plan.size(); k++) begin
      while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= req_plan[k].act;
      req_ch.push_value <= req_plan[k].value;
      @(posedge clk);
      while (!req_ch.ready) @(posedge clk);
    end
    req_ch.valid <= 1'b0;

    while (checked_count < req_plan.size()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
